// File: design/wfcp_pkg.sv
// ----------------------------------------------------------------------------
// wfcp_pkg
// Types and constants shared by the WAV chunk parser modules.
// ----------------------------------------------------------------------------
package wfcp_pkg;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [15:0] PCM_FORMAT_CODE = 16'd1;
    localparam logic [31:0] HDR_LEN         = 32'd12;
    localparam logic [31:0] CHUNK_HDR_LEN   = 32'd8;
    localparam logic [31:0] FMT_LEN         = 32'd16;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_CHUNK  = 4'd1,
        PH_FMT    = 4'd2,
        PH_SKIP   = 4'd3,
        PH_DATA   = 4'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_FORMAT = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_HEADER  = 3'd1,
        ST_OUTSIDE     = 3'd2,
        ST_DUP_FMT     = 3'd3,
        ST_DATA_NO_FMT = 3'd4,
        ST_UNSUPPORTED = 3'd5,
        ST_NO_DATA     = 3'd6,
        ST_SHORT       = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic        stereo;
        logic        sixteen_bit;
        logic [31:0] sample_rate;
        logic [31:0] frame_count;
        logic [7:0]  data_byte;
        logic        last;
    } t_out_item;

endpackage

// File: design/wfcp_core.sv
// ----------------------------------------------------------------------------
// wfcp_core
// Parse state and the per-byte next-state logic. One byte is consumed on each
// cycle that i_step is high; at most one result comes out with it.
// ----------------------------------------------------------------------------
module wfcp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  wfcp_pkg::t_in_item  i_item,
    input  logic [31:0]         i_file_length,
    output logic                o_res_valid,
    output wfcp_pkg::t_out_item o_res
);

    logic [31:0]      r_pos, n_pos;
    wfcp_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_hdr, n_hdr;
    logic [31:0]      r_chunk, n_chunk;
    logic [31:0]      r_left, n_left;
    logic             r_have_fmt, n_have_fmt;
    logic [15:0]      r_fmt_code, n_fmt_code;
    logic [15:0]      r_chans, n_chans;
    logic [31:0]      r_rate, n_rate;
    logic [15:0]      r_bits, n_bits;
    logic [4:0]       r_fmt_idx, n_fmt_idx;
    logic             r_stopped, n_stopped;

    logic [31:0]      c_pos;
    wfcp_pkg::t_phase c_phase;
    logic [31:0]      c_hdr;
    logic [31:0]      c_chunk;
    logic [31:0]      c_left;
    logic             c_have_fmt;
    logic [15:0]      c_fmt_code;
    logic [15:0]      c_chans;
    logic [31:0]      c_rate;
    logic [15:0]      c_bits;
    logic [4:0]       c_fmt_idx;
    logic             c_stopped;

    logic [7:0]       b;
    logic [32:0]      offset;
    logic [33:0]      len_w;
    logic [31:0]      hdr_sh;
    logic             fail_en;
    wfcp_pkg::t_status fail_code;
    logic             next_en;
    logic             fmt_stereo;
    logic             fmt_s16;
    logic [1:0]       shamt;

    always_comb begin
        b      = i_item.file_byte;
        len_w  = {2'b00, i_file_length};

        if (i_item.first) begin
            c_pos      = '0;
            c_phase    = wfcp_pkg::PH_HEADER;
            c_hdr      = '0;
            c_chunk    = '0;
            c_left     = '0;
            c_have_fmt = 1'b0;
            c_fmt_code = '0;
            c_chans    = '0;
            c_rate     = '0;
            c_bits     = '0;
            c_fmt_idx  = '0;
            c_stopped  = 1'b0;
        end else begin
            c_pos      = r_pos;
            c_phase    = r_phase;
            c_hdr      = r_hdr;
            c_chunk    = r_chunk;
            c_left     = r_left;
            c_have_fmt = r_have_fmt;
            c_fmt_code = r_fmt_code;
            c_chans    = r_chans;
            c_rate     = r_rate;
            c_bits     = r_bits;
            c_fmt_idx  = r_fmt_idx;
            c_stopped  = r_stopped;
        end

        n_pos      = c_pos;
        n_phase    = c_phase;
        n_hdr      = c_hdr;
        n_chunk    = c_chunk;
        n_left     = c_left;
        n_have_fmt = c_have_fmt;
        n_fmt_code = c_fmt_code;
        n_chans    = c_chans;
        n_rate     = c_rate;
        n_bits     = c_bits;
        n_fmt_idx  = c_fmt_idx;
        n_stopped  = c_stopped;

        offset     = {1'b0, c_pos} + 33'd1;
        hdr_sh     = {b, c_hdr[31:8]};
        fail_en    = 1'b0;
        fail_code  = wfcp_pkg::ST_OK;
        next_en    = 1'b0;
        fmt_stereo = (c_chans == 16'd2);
        fmt_s16    = (c_bits == 16'd16);
        shamt      = {1'b0, fmt_stereo} + {1'b0, fmt_s16};
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!c_stopped) begin
            n_pos = c_pos + 32'd1;
            case (c_phase)
                wfcp_pkg::PH_HEADER: begin
                    n_hdr = hdr_sh;
                    if (c_pos == 32'd0 && i_file_length < wfcp_pkg::HDR_LEN) begin
                        fail_en   = 1'b1;
                        fail_code = wfcp_pkg::ST_BAD_HEADER;
                    end else if (c_pos == 32'd3 && hdr_sh != wfcp_pkg::ID_RIFF) begin
                        fail_en   = 1'b1;
                        fail_code = wfcp_pkg::ST_BAD_HEADER;
                    end else if (c_pos == 32'd11) begin
                        if (hdr_sh != wfcp_pkg::ID_WAVE) begin
                            fail_en   = 1'b1;
                            fail_code = wfcp_pkg::ST_BAD_HEADER;
                        end else begin
                            next_en = 1'b1;
                        end
                    end else if (c_pos > 32'd11) begin
                        fail_en   = 1'b1;
                        fail_code = wfcp_pkg::ST_BAD_HEADER;
                    end
                end
                wfcp_pkg::PH_CHUNK: begin
                    if (c_left > 32'd4) begin
                        n_hdr = hdr_sh;
                    end else begin
                        n_chunk = {b, c_chunk[31:8]};
                    end
                    n_left = c_left - 32'd1;
                    if (n_left == 32'd0) begin
                        if (({1'b0, offset} + {2'b00, n_chunk}) > len_w) begin
                            fail_en   = 1'b1;
                            fail_code = wfcp_pkg::ST_OUTSIDE;
                        end else if (c_hdr == wfcp_pkg::ID_FMT) begin
                            if (c_have_fmt) begin
                                fail_en   = 1'b1;
                                fail_code = wfcp_pkg::ST_DUP_FMT;
                            end else if (n_chunk < wfcp_pkg::FMT_LEN) begin
                                fail_en   = 1'b1;
                                fail_code = wfcp_pkg::ST_SHORT;
                            end else begin
                                n_have_fmt = 1'b1;
                                n_fmt_code = '0;
                                n_chans    = '0;
                                n_rate     = '0;
                                n_bits     = '0;
                                n_fmt_idx  = '0;
                                n_left     = n_chunk;
                                n_phase    = wfcp_pkg::PH_FMT;
                            end
                        end else if (c_hdr == wfcp_pkg::ID_DATA) begin
                            if (!c_have_fmt) begin
                                fail_en   = 1'b1;
                                fail_code = wfcp_pkg::ST_DATA_NO_FMT;
                            end else if (c_fmt_code != wfcp_pkg::PCM_FORMAT_CODE ||
                                         c_rate == 32'd0 ||
                                         (c_chans != 16'd1 && c_chans != 16'd2) ||
                                         (c_bits != 16'd8 && c_bits != 16'd16)) begin
                                fail_en   = 1'b1;
                                fail_code = wfcp_pkg::ST_UNSUPPORTED;
                            end else begin
                                o_res_valid       = 1'b1;
                                o_res.kind        = wfcp_pkg::KIND_FORMAT;
                                o_res.status      = wfcp_pkg::ST_OK;
                                o_res.stereo      = fmt_stereo;
                                o_res.sixteen_bit = fmt_s16;
                                o_res.sample_rate = c_rate;
                                o_res.frame_count = n_chunk >> shamt;
                                if (n_chunk == 32'd0) begin
                                    n_stopped  = 1'b1;
                                    o_res.last = 1'b1;
                                end else begin
                                    n_left  = n_chunk;
                                    n_phase = wfcp_pkg::PH_DATA;
                                end
                            end
                        end else begin
                            n_left = n_chunk;
                            if (n_chunk == 32'd0) begin
                                next_en = 1'b1;
                            end else begin
                                n_phase = wfcp_pkg::PH_SKIP;
                            end
                        end
                    end
                end
                wfcp_pkg::PH_FMT, wfcp_pkg::PH_SKIP: begin
                    if (c_phase == wfcp_pkg::PH_FMT) begin
                        if (c_fmt_idx < 5'd2) begin
                            n_fmt_code[8*c_fmt_idx[0] +: 8] = b;
                        end else if (c_fmt_idx < 5'd4) begin
                            n_chans[8*c_fmt_idx[0] +: 8] = b;
                        end else if (c_fmt_idx < 5'd8) begin
                            n_rate[8*c_fmt_idx[1:0] +: 8] = b;
                        end else if (c_fmt_idx >= 5'd14 && c_fmt_idx < 5'd16) begin
                            n_bits[8*c_fmt_idx[0] +: 8] = b;
                        end
                        if (c_fmt_idx < 5'd16) begin
                            n_fmt_idx = c_fmt_idx + 5'd1;
                        end
                    end
                    if (c_left != 32'd0) begin
                        n_left = c_left - 32'd1;
                    end
                    if (n_left == 32'd0) begin
                        next_en = 1'b1;
                    end
                end
                wfcp_pkg::PH_DATA: begin
                    if (c_left != 32'd0) begin
                        n_left = c_left - 32'd1;
                    end
                    o_res_valid     = 1'b1;
                    o_res.kind      = wfcp_pkg::KIND_DATA;
                    o_res.status    = wfcp_pkg::ST_OK;
                    o_res.data_byte = b;
                    o_res.last      = (n_left == 32'd0);
                    if (n_left == 32'd0) begin
                        n_stopped = 1'b1;
                    end
                end
                default: begin
                    n_stopped = 1'b1;
                end
            endcase

            if (next_en) begin
                if ({1'b0, offset} == len_w) begin
                    fail_en   = 1'b1;
                    fail_code = wfcp_pkg::ST_NO_DATA;
                end else if (({1'b0, offset} + {2'b00, wfcp_pkg::CHUNK_HDR_LEN}) > len_w) begin
                    fail_en   = 1'b1;
                    fail_code = wfcp_pkg::ST_SHORT;
                end else begin
                    n_phase = wfcp_pkg::PH_CHUNK;
                    n_left  = wfcp_pkg::CHUNK_HDR_LEN;
                    n_hdr   = '0;
                    n_chunk = '0;
                end
            end

            if (fail_en) begin
                n_stopped    = 1'b1;
                o_res_valid  = 1'b1;
                o_res        = '0;
                o_res.kind   = wfcp_pkg::KIND_ERROR;
                o_res.status = fail_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_phase    <= wfcp_pkg::PH_HEADER;
            r_hdr      <= '0;
            r_chunk    <= '0;
            r_left     <= '0;
            r_have_fmt <= 1'b0;
            r_fmt_code <= '0;
            r_chans    <= '0;
            r_rate     <= '0;
            r_bits     <= '0;
            r_fmt_idx  <= '0;
            r_stopped  <= 1'b0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_hdr      <= n_hdr;
            r_chunk    <= n_chunk;
            r_left     <= n_left;
            r_have_fmt <= n_have_fmt;
            r_fmt_code <= n_fmt_code;
            r_chans    <= n_chans;
            r_rate     <= n_rate;
            r_bits     <= n_bits;
            r_fmt_idx  <= n_fmt_idx;
            r_stopped  <= n_stopped;
        end
    end

endmodule

// File: design/wfcp_out_stage.sv
// ----------------------------------------------------------------------------
// wfcp_out_stage
// Result register on the output channel.
// ----------------------------------------------------------------------------
module wfcp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_res_valid,
    input  wfcp_pkg::t_out_item i_res,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output wfcp_pkg::t_out_item o_out_data
);

    logic                r_valid;
    wfcp_pkg::t_out_item r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_data <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// File: design/wave_file_chunk_parser.sv
// An input byte is registered in the input stage and its result in the output stage.
// Throughput: one input byte per cycle, sustained, while the output is taken.
// The per-byte parse step is one pass through wfcp_core between two registers.
// Reset: i_rst_n is synchronous, active low; it empties both stages, clears
// file_length to zero and restarts the parse at the file header.
// ----------------------------------------------------------------------------
// wave_file_chunk_parser
// Streaming RIFF/WAVE header parser: checks the file header, walks chunks,
// reports the format and forwards the sample data bytes, or reports an error.
// ----------------------------------------------------------------------------
module wave_file_chunk_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wfcp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wfcp_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);

    logic               r_in_valid;
    wfcp_pkg::t_in_item r_in;
    logic [31:0]        r_file_length;
    logic               advance;
    logic               res_valid;
    wfcp_pkg::t_out_item res;

    assign advance     = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_file_length <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid) begin
                r_file_length <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    wfcp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_item        (r_in),
        .i_file_length (r_file_length),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    wfcp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("input stage dropped a beat");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_error_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == wfcp_pkg::KIND_ERROR |->
            o_out_data.status != wfcp_pkg::ST_OK && o_out_data.last == 1'b0)
        else $error("malformed error beat");

    a_advance_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !res_valid |=> !o_out_valid)
        else $error("output valid without a result");

endmodule

// File: dv/tb_wave_file_chunk_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wave_file_chunk_parser
// Feeds WAV byte streams into the chunk parser, well-formed files with
// random content plus corrupted, truncated and noise streams. A local parse
// model predicts every result beat. Output beats are checked field by field,
// under several sender idle and receiver stall patterns and file lengths.
// ----------------------------------------------------------------------------
module tb_wave_file_chunk_parser;
    import wfcp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        o_cfg_ready;

    logic        in_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          squeeze = 1'b0;
    bit          hold_off = 1'b0;
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          mismatches = 0;

    t_in_item    pending_bytes[$];
    t_out_item   pending_results[$];
    logic [7:0]  file_bytes[$];

    logic [31:0] file_len_reg;
    logic [31:0] next_pos;
    t_phase      phase;
    logic [31:0] id_word;
    logic [31:0] chunk_len;
    logic [31:0] remaining;
    bit          fmt_seen;
    logic [15:0] fmt_code;
    logic [15:0] fmt_chans;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_bits;
    logic [4:0]  fmt_idx;
    bit          halted;

    wave_file_chunk_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_parse();
        next_pos = '0;
        phase = PH_HEADER;
        id_word = '0;
        chunk_len = '0;
        remaining = '0;
        fmt_seen = 1'b0;
        fmt_code = '0;
        fmt_chans = '0;
        fmt_rate = '0;
        fmt_bits = '0;
        fmt_idx = '0;
        halted = 1'b0;
    endfunction

    function automatic bit stop_with(t_status code, output t_out_item r);
        r = '0;
        r.kind = KIND_ERROR;
        r.status = code;
        halted = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit begin_chunk(logic [63:0] off, output t_out_item r);
        r = '0;
        if (off == 64'(file_len_reg)) return stop_with(ST_NO_DATA, r);
        if (off > 64'(file_len_reg) || 64'(file_len_reg) - off < 64'(CHUNK_HDR_LEN))
            return stop_with(ST_SHORT, r);
        phase = PH_CHUNK;
        remaining = CHUNK_HDR_LEN;
        id_word = '0;
        chunk_len = '0;
        return 1'b0;
    endfunction

    function automatic bit parse_byte(t_in_item it, output t_out_item r);
        logic [7:0]  b;
        logic [31:0] p;
        logic [63:0] off;
        int          sh;
        r = '0;
        b = it.file_byte;
        if (it.first) restart_parse();
        if (halted) return 1'b0;
        p = next_pos;
        next_pos = p + 32'd1;
        off = 64'(p) + 64'd1;
        case (phase)
            PH_HEADER: begin
                if (p == 0 && file_len_reg < HDR_LEN) return stop_with(ST_BAD_HEADER, r);
                id_word = {b, id_word[31:8]};
                if (p == 3 && id_word != ID_RIFF) return stop_with(ST_BAD_HEADER, r);
                if (p == 11) begin
                    if (id_word != ID_WAVE) return stop_with(ST_BAD_HEADER, r);
                    return begin_chunk(off, r);
                end
                if (p > 11) return stop_with(ST_BAD_HEADER, r);
                return 1'b0;
            end
            PH_CHUNK: begin
                if (remaining > 4) id_word = {b, id_word[31:8]};
                else chunk_len = {b, chunk_len[31:8]};
                remaining = remaining - 32'd1;
                if (remaining != 0) return 1'b0;
                if (off + 64'(chunk_len) > 64'(file_len_reg)) return stop_with(ST_OUTSIDE, r);
                if (id_word == ID_FMT) begin
                    if (fmt_seen) return stop_with(ST_DUP_FMT, r);
                    if (chunk_len < FMT_LEN) return stop_with(ST_SHORT, r);
                    fmt_seen = 1'b1;
                    fmt_code = '0;
                    fmt_chans = '0;
                    fmt_rate = '0;
                    fmt_bits = '0;
                    fmt_idx = '0;
                    remaining = chunk_len;
                    phase = PH_FMT;
                    return 1'b0;
                end
                if (id_word == ID_DATA) begin
                    if (!fmt_seen) return stop_with(ST_DATA_NO_FMT, r);
                    if (fmt_code != PCM_FORMAT_CODE || fmt_rate == 0 ||
                        (fmt_chans != 1 && fmt_chans != 2) ||
                        (fmt_bits != 8 && fmt_bits != 16))
                        return stop_with(ST_UNSUPPORTED, r);
                    sh = ((fmt_chans == 2) ? 1 : 0) + ((fmt_bits == 16) ? 1 : 0);
                    r.kind = KIND_FORMAT;
                    r.stereo = (fmt_chans == 2);
                    r.sixteen_bit = (fmt_bits == 16);
                    r.sample_rate = fmt_rate;
                    r.frame_count = chunk_len >> sh;
                    if (chunk_len == 0) begin
                        halted = 1'b1;
                        r.last = 1'b1;
                    end else begin
                        remaining = chunk_len;
                        phase = PH_DATA;
                    end
                    return 1'b1;
                end
                remaining = chunk_len;
                if (remaining == 0) return begin_chunk(off, r);
                phase = PH_SKIP;
                return 1'b0;
            end
            PH_FMT, PH_SKIP: begin
                if (phase == PH_FMT) begin
                    if (fmt_idx < 2) fmt_code[fmt_idx * 8 +: 8] = b;
                    else if (fmt_idx < 4) fmt_chans[(fmt_idx - 2) * 8 +: 8] = b;
                    else if (fmt_idx < 8) fmt_rate[(fmt_idx - 4) * 8 +: 8] = b;
                    else if (fmt_idx >= 14 && fmt_idx < 16)
                        fmt_bits[(fmt_idx - 14) * 8 +: 8] = b;
                    if (fmt_idx < 16) fmt_idx = fmt_idx + 5'd1;
                end
                if (remaining > 0) remaining = remaining - 32'd1;
                if (remaining == 0) return begin_chunk(off, r);
                return 1'b0;
            end
            PH_DATA: begin
                if (remaining > 0) remaining = remaining - 32'd1;
                if (remaining == 0) halted = 1'b1;
                r.kind = KIND_DATA;
                r.data_byte = b;
                r.last = (remaining == 0);
                return 1'b1;
            end
            default: begin
                halted = 1'b1;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void push_item(logic [7:0] b, bit f);
        t_in_item it;
        it.file_byte = b;
        it.first = f;
        pending_bytes.push_back(it);
        bytes_queued++;
    endfunction

    function automatic void put_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) file_bytes.push_back(w[8 * i +: 8]);
    endfunction

    function automatic void put_chunk(logic [31:0] id, logic [31:0] size);
        put_word(id);
        put_word(size);
        for (int i = 0; i < 160 && i < size; i++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic int flush_file(bit mark_first);
        foreach (file_bytes[i]) push_item(file_bytes[i], mark_first && i == 0);
        return file_bytes.size();
    endfunction

    function automatic int queue_file(logic [31:0] len);
        int          sel;
        int          n;
        logic [31:0] sz;
        logic [31:0] rate;
        logic [31:0] room;
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] bits;
        file_bytes.delete();
        sel = $urandom_range(0, 19);
        if (sel == 9) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return n;
        end
        put_word(ID_RIFF);
        put_word($urandom);
        put_word(ID_WAVE);
        if (sel == 0) begin
            n = ($urandom_range(0, 1) ? 0 : 8) + $urandom_range(0, 3);
            file_bytes[n] = file_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
        end
        if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 5));
        if (sel == 2) begin
            put_chunk(ID_FMT, $urandom_range(0, 15));
        end else if (sel != 1) begin
            sz = ($urandom_range(0, 3) == 0) ? 16 + $urandom_range(1, 6) : 16;
            code = PCM_FORMAT_CODE;
            chans = 16'($urandom_range(1, 2));
            bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
            rate = $urandom;
            if (sel == 3) begin
                case ($urandom_range(0, 3))
                    0: code = 16'($urandom_range(0, 3));
                    1: chans = 16'($urandom_range(0, 4));
                    2: rate = '0;
                    default: bits = 16'($urandom_range(0, 24));
                endcase
            end
            put_word(ID_FMT);
            put_word(sz);
            put_word({chans, code});
            put_word(rate);
            put_word($urandom);
            put_word({bits, 16'($urandom_range(0, 65535))});
            for (int i = 16; i < sz; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (sel == 4) begin
            put_word(ID_FMT);
            put_word(FMT_LEN);
        end
        if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 5));
        if (longint'(len) >= longint'(file_bytes.size()) + 8) begin
            room = len - file_bytes.size() - 8;
            if (sel == 6) sz = room + $urandom_range(1, 3);
            else if (sel == 7) sz = $urandom;
            else sz = room;
        end else begin
            sz = $urandom_range(0, 8);
        end
        put_chunk((sel == 5) ? $urandom : ID_DATA, sz);
        if (sel == 8) begin
            n = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > n) void'(file_bytes.pop_back());
        end
        return flush_file($urandom_range(0, 15) != 0);
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic write_file_length(logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (bytes_taken != bytes_queued || pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    always @(posedge clk) begin
        t_out_item want;
        t_out_item got;
        in_taken <= rst_n && in_valid && o_in_ready;
        cfg_taken <= rst_n && cfg_valid && o_cfg_ready;
        if (rst_n) begin
            if (o_out_valid && out_ready) begin
                got = o_out_data;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, got %0h", $time, got);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(got.kind));
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("stereo", 32'(want.stereo), 32'(got.stereo));
                    compare_field("sixteen_bit", 32'(want.sixteen_bit),
                                  32'(got.sixteen_bit));
                    compare_field("sample_rate", want.sample_rate, got.sample_rate);
                    compare_field("frame_count", want.frame_count, got.frame_count);
                    compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
                    compare_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (cfg_valid && o_cfg_ready) file_len_reg = cfg_data;
            if (in_valid && o_in_ready) begin
                bytes_taken++;
                if (parse_byte(in_data, want)) pending_results.push_back(want);
            end
        end
    end

    always @(negedge clk) begin
        if (!in_valid || in_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data <= pending_bytes.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        wait (squeeze);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("wave_file_chunk_parser regression: fail");
        $finish;
    end

    initial begin
        logic [31:0] len;
        int          queued;
        file_len_reg = '0;
        restart_parse();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        write_file_length('0);
        push_item(8'h52, 1'b0);
        push_item(8'h49, 1'b0);
        drain();
        write_file_length(HDR_LEN);
        file_bytes.delete();
        put_word(ID_RIFF);
        put_word($urandom);
        put_word(ID_WAVE);
        void'(flush_file(1'b1));
        file_bytes.delete();
        put_word(ID_RIFF ^ 32'h0100_0000);
        void'(flush_file(1'b1));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = (ph % 4 == 1) ? 78 : (ph % 4 == 3) ? 31 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 78 : (ph % 4 == 3) ? 31 : 0;
            case (ph)
                0: len = 44 + $urandom_range(0, 40);
                1: len = 44 + $urandom_range(0, 150);
                2: len = 32'hFFFF_FFFF;
                3: len = $urandom_range(13, 19);
                4: len = 44;
                5: len = 60 + $urandom_range(0, 140);
                6: len = $urandom_range(20, 60);
                default: len = 60 + $urandom_range(0, 60);
            endcase
            write_file_length(len);
            queued = 0;
            while (queued < 190) queued += queue_file(len);
            if (ph == 0) squeeze = 1'b1;
            drain();
        end

        if (mismatches == 0) begin
            $display("wave_file_chunk_parser regression: pass");
        end else begin
            $display("wave_file_chunk_parser regression: fail");
        end
        $finish;
    end

endmodule
